FILE: hdl/matrix_inverse_4x4_top_assert.svh
// Assertion macros for the 4x4 matrix inverse block.
// Used by matrix_inverse_4x4_top; depends on nothing else.
`ifndef MATRIX_INVERSE_4X4_TOP_ASSERT_SVH
`define MATRIX_INVERSE_4X4_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define MI4_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define MI4_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/mi4_pkg.sv
// Shared types, constants and step decoder for the 4x4 matrix inverse.
// Used by mi4_ctrl, mi4_dp and matrix_inverse_4x4_top; no dependencies.
package mi4_pkg;

   localparam int ELEM_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int OP_W       = 65;    // operand store word: element or minor
   localparam int RAM_DEPTH  = 28;    // 16 elements + 12 minors
   localparam int ADDR_W     = 5;
   localparam int MINOR_BASE = 16;
   localparam int LIMB_W     = 32;
   localparam int EXT_W      = 96;    // three limbs
   localparam int PP_W       = 64;
   localparam int PROD_W     = 132;
   localparam int ACC_W      = 136;
   localparam int DIV_W      = 166;
   localparam int Q_W        = 32;
   localparam int NUM_SHIFT  = 2 * FRAC_W + 1;

   typedef enum logic [1:0] {
      PH_MINOR,
      PH_DET,
      PH_ADJ
   } phase_type;

   typedef enum logic [1:0] {
      DEST_NONE,
      DEST_MINOR,
      DEST_DET,
      DEST_DIV
   } dest_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
      logic              clear;
      logic              neg;
      dest_type          dest;
   } step_type;

   // Controller to datapath commands
   typedef struct packed {
      logic              ram_we;
      logic              wsel_load;
      logic [ADDR_W-1:0] waddr;
      logic [ADDR_W-1:0] raddr;
      logic              cap_a;
      logic              cap_b;
      logic              prod_clr;
      logic              mul_en;
      logic [1:0]        li;
      logic [1:0]        lj;
      logic              acc_en;
      logic              acc_clear;
      logic              acc_neg;
      logic              det_load;
      logic              div_init;
      logic              div_en;
      logic              emit;
      logic              emit_sing;
      logic [3:0]        out_index;
   } cmd_type;

   typedef struct packed {
      logic det_zero;
   } status_type;

   // minor k = e[a]*e[b] - e[c]*e[d]
   localparam logic [3:0] MINOR_TAB [12][4] = '{
      '{4'd0, 4'd5, 4'd4, 4'd1},    '{4'd0, 4'd6, 4'd4, 4'd2},
      '{4'd0, 4'd7, 4'd4, 4'd3},    '{4'd1, 4'd6, 4'd5, 4'd2},
      '{4'd1, 4'd7, 4'd5, 4'd3},    '{4'd2, 4'd7, 4'd6, 4'd3},
      '{4'd8, 4'd13, 4'd12, 4'd9},  '{4'd8, 4'd14, 4'd12, 4'd10},
      '{4'd8, 4'd15, 4'd12, 4'd11}, '{4'd9, 4'd14, 4'd13, 4'd10},
      '{4'd9, 4'd15, 4'd13, 4'd11}, '{4'd10, 4'd15, 4'd14, 4'd11}
   };

   // adjugate: sign, then (element, minor) pairs for +, -, + terms
   localparam logic [3:0] ADJ_TAB [16][7] = '{
      '{4'd0, 4'd5, 4'd11, 4'd6, 4'd10, 4'd7, 4'd9},
      '{4'd1, 4'd1, 4'd11, 4'd2, 4'd10, 4'd3, 4'd9},
      '{4'd0, 4'd13, 4'd5, 4'd14, 4'd4, 4'd15, 4'd3},
      '{4'd1, 4'd9, 4'd5, 4'd10, 4'd4, 4'd11, 4'd3},
      '{4'd1, 4'd4, 4'd11, 4'd6, 4'd8, 4'd7, 4'd7},
      '{4'd0, 4'd0, 4'd11, 4'd2, 4'd8, 4'd3, 4'd7},
      '{4'd1, 4'd12, 4'd5, 4'd14, 4'd2, 4'd15, 4'd1},
      '{4'd0, 4'd8, 4'd5, 4'd10, 4'd2, 4'd11, 4'd1},
      '{4'd0, 4'd4, 4'd10, 4'd5, 4'd8, 4'd7, 4'd6},
      '{4'd1, 4'd0, 4'd10, 4'd1, 4'd8, 4'd3, 4'd6},
      '{4'd0, 4'd12, 4'd4, 4'd13, 4'd2, 4'd15, 4'd0},
      '{4'd1, 4'd8, 4'd4, 4'd9, 4'd2, 4'd11, 4'd0},
      '{4'd1, 4'd4, 4'd9, 4'd5, 4'd7, 4'd6, 4'd6},
      '{4'd0, 4'd0, 4'd9, 4'd1, 4'd7, 4'd2, 4'd6},
      '{4'd1, 4'd12, 4'd3, 4'd13, 4'd1, 4'd14, 4'd0},
      '{4'd0, 4'd8, 4'd3, 4'd9, 4'd1, 4'd10, 4'd0}
   };

   // Decode one multiply-accumulate step of the program
   function automatic step_type step_info(phase_type ph, logic [3:0] item,
                                          logic [1:0] sub);
      step_type s;
      logic     sgn;
      s   = '0;
      sgn = ADJ_TAB[item][0][0];
      case (ph)
         PH_MINOR: begin
            if (sub == 2'd0) begin
               s.addr_a = {1'b0, MINOR_TAB[item][0]};
               s.addr_b = {1'b0, MINOR_TAB[item][1]};
               s.clear  = 1'b1;
            end else begin
               s.addr_a = {1'b0, MINOR_TAB[item][2]};
               s.addr_b = {1'b0, MINOR_TAB[item][3]};
               s.neg    = 1'b1;
               s.dest   = DEST_MINOR;
            end
         end
         PH_DET: begin
            s.addr_a = ADDR_W'(MINOR_BASE) + {1'b0, item};
            s.addr_b = ADDR_W'(MINOR_BASE + 11) - {1'b0, item};
            s.clear  = (item == 4'd0);
            s.neg    = (item == 4'd1) || (item == 4'd4);
            s.dest   = (item == 4'd5) ? DEST_DET : DEST_NONE;
         end
         PH_ADJ: begin
            case (sub)
               2'd0: begin
                  s.addr_a = {1'b0, ADJ_TAB[item][1]};
                  s.addr_b = ADDR_W'(MINOR_BASE) + {1'b0, ADJ_TAB[item][2]};
                  s.clear  = 1'b1;
                  s.neg    = sgn;
               end
               2'd1: begin
                  s.addr_a = {1'b0, ADJ_TAB[item][3]};
                  s.addr_b = ADDR_W'(MINOR_BASE) + {1'b0, ADJ_TAB[item][4]};
                  s.neg    = ~sgn;
               end
               default: begin
                  s.addr_a = {1'b0, ADJ_TAB[item][5]};
                  s.addr_b = ADDR_W'(MINOR_BASE) + {1'b0, ADJ_TAB[item][6]};
                  s.neg    = sgn;
                  s.dest   = DEST_DIV;
               end
            endcase
         end
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

FILE: hdl/mi4_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mi4_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/mi4_dp.sv
// Datapath: operand store, limb multiplier, accumulator, divider, outputs.
// Depends on mi4_pkg and mi4_ram.
module mi4_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  mi4_pkg::cmd_type            cmd,
   output mi4_pkg::status_type         status,
   input  logic signed [31:0]          req_element_value,
   output logic                        rsp_valid,
   output logic signed [31:0]          rsp_inverse_value,
   output logic [3:0]                  rsp_element_index,
   output logic                        rsp_last_element,
   output logic                        rsp_singular
);

   logic [mi4_pkg::OP_W-1:0]   wdata;
   logic [mi4_pkg::OP_W-1:0]   rdata;
   logic                       rd_neg;
   logic [mi4_pkg::OP_W-1:0]   rd_mag;
   logic [mi4_pkg::OP_W-1:0]   opa_mag_ff, opb_mag_ff;
   logic                       opa_neg_ff, prod_neg_ff;
   logic [mi4_pkg::EXT_W-1:0]  a_ext, b_ext;
   logic [mi4_pkg::LIMB_W-1:0] a_limb, b_limb;
   logic [mi4_pkg::PP_W-1:0]   pp_ff;
   logic [2:0]                 sh_ff;
   logic                       pp_vld_ff;
   logic [mi4_pkg::PROD_W-1:0] prod_ff;
   logic [mi4_pkg::ACC_W-1:0]  term, acc_in, acc_ff, det_ff;
   logic                       term_neg;
   logic [mi4_pkg::ACC_W-1:0]  n_mag, d_mag;
   logic [mi4_pkg::DIV_W-1:0]  x_in, y_in;
   logic [mi4_pkg::DIV_W-1:0]  rem_ff, dv_ff;
   logic [mi4_pkg::Q_W-1:0]    q_ff;
   logic                       ovf_ff, qneg_ff, ge;
   logic [mi4_pkg::Q_W-1:0]    sat_mag;
   logic                       rsp_valid_ff, rsp_last_ff, rsp_sing_ff;
   logic signed [31:0]         rsp_value_ff;
   logic [3:0]                 rsp_index_ff;

   // Operand store: elements while loading, minors while computing
   assign wdata = cmd.wsel_load ? mi4_pkg::OP_W'(req_element_value) : acc_in[mi4_pkg::OP_W-1:0];

   mi4_ram #(
      .WIDTH (mi4_pkg::OP_W),
      .DEPTH (mi4_pkg::RAM_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (cmd.ram_we),
      .waddr (cmd.waddr),
      .wdata (wdata),
      .raddr (cmd.raddr),
      .rdata (rdata)
   );

   // Operand capture as sign and magnitude
   assign rd_neg = rdata[mi4_pkg::OP_W-1];
   assign rd_mag = rd_neg ? (~rdata + 1'b1) : rdata;

   always_ff @(posedge clock) begin
      if (cmd.cap_a) begin
         opa_mag_ff <= rd_mag;
         opa_neg_ff <= rd_neg;
      end
      if (cmd.cap_b) begin
         opb_mag_ff  <= rd_mag;
         prod_neg_ff <= opa_neg_ff ^ rd_neg;
      end
   end

   // 32x32 limb products, registered, then shifted into the product
   assign a_ext  = mi4_pkg::EXT_W'(opa_mag_ff);
   assign b_ext  = mi4_pkg::EXT_W'(opb_mag_ff);
   assign a_limb = a_ext[{cmd.li, 5'b0} +: mi4_pkg::LIMB_W];
   assign b_limb = b_ext[{cmd.lj, 5'b0} +: mi4_pkg::LIMB_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_vld_ff <= 1'b0;
      end else begin
         pp_vld_ff <= cmd.mul_en;
      end
      pp_ff <= a_limb * b_limb;
      sh_ff <= {1'b0, cmd.li} + {1'b0, cmd.lj};
      if (cmd.prod_clr) begin
         prod_ff <= '0;
      end else if (pp_vld_ff) begin
         prod_ff <= prod_ff + (mi4_pkg::PROD_W'(pp_ff) << {sh_ff, 5'b0});
      end
   end

   // Signed accumulate of the product
   assign term_neg = prod_neg_ff ^ cmd.acc_neg;
   assign term     = term_neg ? (~mi4_pkg::ACC_W'(prod_ff) + 1'b1) : mi4_pkg::ACC_W'(prod_ff);
   assign acc_in   = (cmd.acc_clear ? '0 : acc_ff) + term;

   always_ff @(posedge clock) begin
      if (cmd.acc_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.det_load) begin
         det_ff <= acc_in;
      end
   end

   assign status.det_zero = (det_ff == '0);

   // Rounded division: q = floor((2^33 N + D) / 2D) over 32 quotient bits
   assign n_mag = acc_ff[mi4_pkg::ACC_W-1] ? (~acc_ff + 1'b1) : acc_ff;
   assign d_mag = det_ff[mi4_pkg::ACC_W-1] ? (~det_ff + 1'b1) : det_ff;
   assign x_in  = (mi4_pkg::DIV_W'(n_mag) << mi4_pkg::NUM_SHIFT) + mi4_pkg::DIV_W'(d_mag);
   assign y_in  = mi4_pkg::DIV_W'(d_mag) << 1;
   assign ge    = (rem_ff >= dv_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff  <= x_in;
         dv_ff   <= y_in << (mi4_pkg::Q_W - 1);
         ovf_ff  <= (x_in >= (y_in << mi4_pkg::Q_W));
         qneg_ff <= acc_ff[mi4_pkg::ACC_W-1] ^ det_ff[mi4_pkg::ACC_W-1];
         q_ff    <= '0;
      end else if (cmd.div_en) begin
         if (ge) begin
            rem_ff <= rem_ff - dv_ff;
         end
         q_ff  <= {q_ff[mi4_pkg::Q_W-2:0], ge};
         dv_ff <= dv_ff >> 1;
      end
   end

   // Saturate to the signed element range
   always_comb begin
      if (qneg_ff) begin
         sat_mag = (ovf_ff || (q_ff > {1'b1, {(mi4_pkg::Q_W-1){1'b0}}}))
                   ? {1'b1, {(mi4_pkg::Q_W-1){1'b0}}} : q_ff;
      end else begin
         sat_mag = (ovf_ff || q_ff[mi4_pkg::Q_W-1])
                   ? {1'b0, {(mi4_pkg::Q_W-1){1'b1}}} : q_ff;
      end
   end

   // Result registers, one strobe per item
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit || cmd.emit_sing;
      end
      if (cmd.emit || cmd.emit_sing) begin
         rsp_index_ff <= cmd.out_index;
         rsp_last_ff  <= (cmd.out_index == 4'd15);
         rsp_sing_ff  <= cmd.emit_sing;
         if (cmd.emit_sing) begin
            rsp_value_ff <= '0;
         end else if (qneg_ff) begin
            rsp_value_ff <= signed'(~sat_mag + 1'b1);
         end else begin
            rsp_value_ff <= signed'(sat_mag);
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_inverse_value = rsp_value_ff;
   assign rsp_element_index = rsp_index_ff;
   assign rsp_last_element  = rsp_last_ff;
   assign rsp_singular      = rsp_sing_ff;

endmodule

FILE: hdl/mi4_ctrl.sv
// Controller: load counter and the step sequencer for minors, determinant,
// adjugate terms and division. Depends on mi4_pkg.
module mi4_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  mi4_pkg::status_type   status,
   output mi4_pkg::cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH_A,
      ST_FETCH_B,
      ST_CAP_B,
      ST_MUL,
      ST_DRAIN,
      ST_ACC,
      ST_DET_CHK,
      ST_DIV_INIT,
      ST_DIV,
      ST_EMIT,
      ST_SING
   } state_type;

   state_type           state_ff;
   mi4_pkg::phase_type  phase_ff;
   logic [3:0]          load_ff;
   logic [3:0]          item_ff;
   logic [1:0]          sub_ff;
   logic [1:0]          li_ff, lj_ff;
   logic [4:0]          cnt_ff;
   mi4_pkg::step_type   step;
   logic                accept;
   logic                last_sub;

   assign step     = mi4_pkg::step_info(phase_ff, item_ff, sub_ff);
   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign last_sub = (phase_ff == mi4_pkg::PH_DET) ||
                     ((phase_ff == mi4_pkg::PH_MINOR) && (sub_ff == 2'd1));

   // Sequencer state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= mi4_pkg::PH_MINOR;
         load_ff  <= '0;
         item_ff  <= '0;
         sub_ff   <= '0;
         li_ff    <= '0;
         lj_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  load_ff <= load_ff + 1'b1;
                  if (load_ff == 4'd15) begin
                     state_ff <= ST_FETCH_A;
                     phase_ff <= mi4_pkg::PH_MINOR;
                     item_ff  <= '0;
                     sub_ff   <= '0;
                  end
               end
            end
            ST_FETCH_A: state_ff <= ST_FETCH_B;
            ST_FETCH_B: state_ff <= ST_CAP_B;
            ST_CAP_B: begin
               state_ff <= ST_MUL;
               li_ff    <= '0;
               lj_ff    <= '0;
            end
            ST_MUL: begin
               if (lj_ff == 2'd2) begin
                  lj_ff <= '0;
                  if (li_ff == 2'd2) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     li_ff <= li_ff + 1'b1;
                  end
               end else begin
                  lj_ff <= lj_ff + 1'b1;
               end
            end
            ST_DRAIN: state_ff <= ST_ACC;
            ST_ACC: begin
               if (step.dest == mi4_pkg::DEST_DIV) begin
                  state_ff <= ST_DIV_INIT;
               end else if (step.dest == mi4_pkg::DEST_DET) begin
                  state_ff <= ST_DET_CHK;
               end else if (last_sub) begin
                  sub_ff   <= '0;
                  state_ff <= ST_FETCH_A;
                  if ((phase_ff == mi4_pkg::PH_MINOR) && (item_ff == 4'd11)) begin
                     phase_ff <= mi4_pkg::PH_DET;
                     item_ff  <= '0;
                  end else begin
                     item_ff <= item_ff + 1'b1;
                  end
               end else begin
                  sub_ff   <= sub_ff + 1'b1;
                  state_ff <= ST_FETCH_A;
               end
            end
            ST_DET_CHK: begin
               item_ff <= '0;
               sub_ff  <= '0;
               if (status.det_zero) begin
                  state_ff <= ST_SING;
               end else begin
                  phase_ff <= mi4_pkg::PH_ADJ;
                  state_ff <= ST_FETCH_A;
               end
            end
            ST_DIV_INIT: begin
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'd31) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               sub_ff <= '0;
               if (item_ff == 4'd15) begin
                  state_ff <= ST_IDLE;
               end else begin
                  item_ff  <= item_ff + 1'b1;
                  state_ff <= ST_FETCH_A;
               end
            end
            ST_SING: begin
               if (item_ff == 4'd15) begin
                  state_ff <= ST_IDLE;
               end else begin
                  item_ff <= item_ff + 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Commands to the datapath
   always_comb begin
      cmd           = '0;
      cmd.wsel_load = (state_ff == ST_IDLE);
      cmd.waddr     = (state_ff == ST_IDLE) ? {1'b0, load_ff}
                      : mi4_pkg::ADDR_W'(mi4_pkg::MINOR_BASE) + {1'b0, item_ff};
      cmd.raddr     = (state_ff == ST_FETCH_B) ? step.addr_b : step.addr_a;
      cmd.li        = li_ff;
      cmd.lj        = lj_ff;
      cmd.acc_clear = step.clear;
      cmd.acc_neg   = step.neg;
      cmd.out_index = item_ff;
      unique case (state_ff)
         ST_IDLE:     cmd.ram_we = accept;
         ST_FETCH_B:  cmd.cap_a = 1'b1;
         ST_CAP_B: begin
            cmd.cap_b    = 1'b1;
            cmd.prod_clr = 1'b1;
         end
         ST_MUL:      cmd.mul_en = 1'b1;
         ST_ACC: begin
            cmd.acc_en   = 1'b1;
            cmd.ram_we   = (step.dest == mi4_pkg::DEST_MINOR);
            cmd.det_load = (step.dest == mi4_pkg::DEST_DET);
         end
         ST_DIV_INIT: cmd.div_init = 1'b1;
         ST_DIV:      cmd.div_en = 1'b1;
         ST_EMIT:     cmd.emit = 1'b1;
         ST_SING:     cmd.emit_sing = 1'b1;
         default:     cmd.ram_we = 1'b0;
      endcase
   end

endmodule

FILE: hdl/matrix_inverse_4x4_top.sv
// Top level of the 4x4 matrix inverse: controller plus datapath.
// Depends on mi4_pkg, mi4_ctrl, mi4_dp and matrix_inverse_4x4_top_assert.svh.
//
// Load sixteen Q16.16 elements in row-major order, one per cycle, with start
// while busy is low. After the sixteenth, busy stays high while the block
// works through 78 multiply-accumulate steps on one shared 32x32 limb
// multiplier (each step: two operand reads from the single-read-port store,
// nine limb products, drain and accumulate), plus a bit-serial rounded
// division per element. The sixteen results appear as one-cycle rsp_valid
// strobes and cannot be stalled; capture them as they come. A singular matrix
// gives sixteen zero results on consecutive cycles with rsp_singular set.
`include "matrix_inverse_4x4_top_assert.svh"

module matrix_inverse_4x4_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_element_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_inverse_value,
   output logic [3:0]         rsp_element_index,
   output logic               rsp_last_element,
   output logic               rsp_singular
);

   mi4_pkg::cmd_type    cmd;
   mi4_pkg::status_type status;

   mi4_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   mi4_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_inverse_value (rsp_inverse_value),
      .rsp_element_index (rsp_element_index),
      .rsp_last_element  (rsp_last_element),
      .rsp_singular      (rsp_singular)
   );

   // Checks
   `MI4_ASSERT_IMP(a_mid_rsp_busy, clock, reset, rsp_valid && !rsp_last_element, busy, "result before the last one while idle")
   `MI4_ASSERT_IMP(a_last_idx, clock, reset, rsp_valid, rsp_last_element == (rsp_element_index == 4'd15), "last flag off index 15")
   `MI4_ASSERT_IMP(a_sing_zero, clock, reset, rsp_valid && rsp_singular, rsp_inverse_value == 32'sd0, "singular result not zero")
   `MI4_ASSERT_NXT(a_load_quiet, clock, reset, start && !busy, !rsp_valid, "result right after a load item")

endmodule
